// ===== hw/rtl/sfbt_pkg.sv =====
// Package for the sorted free-block table: widths, codes and the structs
// passed between the stream wrapper and the table core. No dependencies.
`default_nettype none

package sfbt_pkg;

  // Table geometry.
  localparam int DEPTH   = 256;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Field widths of one transaction.
  localparam int DISK_W  = 4;
  localparam int BLOCK_W = 31;
  localparam int COUNT_W = 9;

  // Stream bus widths; the tdata buses are padded to whole bytes.
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 16;
  localparam int M_TUSER_W = 2;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  // One stored (disk, block) pair.
  typedef struct packed {
    logic [DISK_W-1:0]  disk;
    logic [BLOCK_W-1:0] block;
  } entry_t;

  // Command handed to the core.
  typedef struct packed {
    cmd_e               cmd;
    logic [DISK_W-1:0]  disk_id;
    logic [BLOCK_W-1:0] blk_num;
  } req_t;

  // Result returned by the core.
  typedef struct packed {
    logic [COUNT_W-1:0] entry_count;
    status_e            status;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfbt_core.sv =====
// Table core: the entry memory and the sequencer that scans, inserts and
// removes entries in place. Depends on sfbt_pkg.
`default_nettype none

module sfbt_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  sfbt_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output sfbt_pkg::rsp_t rsp_o
);
  import sfbt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_A_RD = 3'd1;
  localparam logic [2:0] S_A_EV = 3'd2;
  localparam logic [2:0] S_R_RD = 3'd3;
  localparam logic [2:0] S_R_EV = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             found_q, found_d;
  entry_t           carry_q, carry_d;
  entry_t           key_q, key_d;
  status_e          status_q, status_d;

  entry_t           mem_q [DEPTH];
  entry_t           rd_data_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [CNT_W-1:0] k_prev;
  logic             place_here;

  assign k_prev = k_q - 1'b1;

  // The new pair goes ahead of the first entry with disk >= and block >.
  assign place_here = (key_q.disk <= rd_data_q.disk) && (key_q.block < rd_data_q.block);

  // Entry memory: at most one write and one registered read each cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[k_q[IDX_W-1:0]];
  end

  // Sequencer. An add carries the displaced entry forward one slot per
  // step; a remove copies every entry after the hit one slot down.
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    count_d   = count_q;
    found_d   = found_q;
    carry_d   = carry_q;
    key_d     = key_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = k_q[IDX_W-1:0];
    mem_wdata = carry_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          key_d    = '{disk: req_i.disk_id, block: req_i.blk_num};
          carry_d  = '{disk: req_i.disk_id, block: req_i.blk_num};
          k_d      = '0;
          found_d  = 1'b0;
          status_d = STATUS_OK;
          if (req_i.cmd == CMD_REMOVE) begin
            state_d = S_R_RD;
          end else if (count_q >= FULL_COUNT) begin
            status_d = STATUS_FULL;
            state_d  = S_DONE;
          end else begin
            state_d = S_A_RD;
          end
        end
      end
      S_A_RD: begin
        if (k_q == count_q) begin
          // End of the table: the last carried entry lands here.
          mem_we  = 1'b1;
          count_d = count_q + 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_A_EV;
        end
      end
      S_A_EV: begin
        if (found_q || place_here) begin
          mem_we  = 1'b1;
          carry_d = rd_data_q;
          found_d = 1'b1;
        end
        k_d     = k_q + 1'b1;
        state_d = S_A_RD;
      end
      S_R_RD: begin
        if (k_q == count_q) begin
          if (found_q) begin
            count_d = count_q - 1'b1;
          end else begin
            status_d = STATUS_NOT_FOUND;
          end
          state_d = S_DONE;
        end else begin
          state_d = S_R_EV;
        end
      end
      S_R_EV: begin
        if (found_q) begin
          mem_we    = 1'b1;
          mem_waddr = k_prev[IDX_W-1:0];
          mem_wdata = rd_data_q;
        end else if (rd_data_q == key_q) begin
          found_d = 1'b1;
        end
        k_d     = k_q + 1'b1;
        state_d = S_R_RD;
      end
      S_DONE: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      k_q      <= '0;
      found_q  <= 1'b0;
      status_q <= STATUS_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      k_q      <= k_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    key_q   <= key_d;
  end

  assign req_ready_o       = (state_q == S_IDLE);
  assign rsp_valid_o       = (state_q == S_DONE);
  assign rsp_o.entry_count = COUNT_W'(count_q);
  assign rsp_o.status      = status_q;

  // The count never passes the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_COUNT)
    else $error("entry count above table size");

  // The count only changes on the step that finishes a command.
  a_count_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (state_q == S_DONE))
    else $error("entry count changed in mid command");

  // A full refusal is only reported with a full table.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (status_q == STATUS_FULL)) |-> (count_q == FULL_COUNT))
    else $error("full status with free entries");

  // Evaluation steps only look at held entries.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_A_EV) || (state_q == S_R_EV)) |-> (k_q < count_q))
    else $error("scan ran past the held entries");

  // An append at the end never happens into a full table.
  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q == S_A_RD)) |-> (count_q < FULL_COUNT))
    else $error("append into a full table");

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_free_block_table.sv =====
// Top level of the sorted free-block table: stream ports, command unpacking
// and the result register. Depends on sfbt_pkg and sfbt_core.
//
//  Channel   Dir  Contents
//  s_axis    in   tuser[0] cmd; tdata[3:0] disk_id, [34:4] blk_num
//  m_axis    out  tdata[8:0] entry_count; tuser[1:0] status
//
// An add or remove scans the held entries one at a time, each in a read
// state and then an evaluate state; a refused add skips the scan. The
// memory's single read port sets this pace.
// Reset clears the count; the entry memory is not cleared, as only held
// entries are read. A command is taken whenever the core is idle, even while
// the previous result waits in the output register.
`default_nettype none

module sorted_free_block_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sfbt_pkg::S_TDATA_W-1:0] s_axis_tdata,  // disk_id, blk_num
  input  logic                           s_axis_tuser,  // cmd
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sfbt_pkg::M_TDATA_W-1:0] m_axis_tdata,  // entry_count
  output logic [sfbt_pkg::M_TUSER_W-1:0] m_axis_tuser   // status
);
  import sfbt_pkg::*;

  req_t               req;
  rsp_t               rsp;
  logic               rsp_valid;
  logic               rsp_ready;
  logic               out_valid_q;
  logic [COUNT_W-1:0] out_count_q;
  status_e            out_status_q;

  // Unpack the incoming transaction.
  assign req.cmd      = cmd_e'(s_axis_tuser);
  assign req.disk_id  = s_axis_tdata[DISK_W-1:0];
  assign req.blk_num  = s_axis_tdata[DISK_W+BLOCK_W-1:DISK_W];

  sfbt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  // Output register: refilled when empty or when its result leaves.
  assign rsp_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && rsp_ready) begin
      out_count_q  <= rsp.entry_count;
      out_status_q <= rsp.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - COUNT_W){1'b0}}, out_count_q};
  assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the sorted free-block table. It drives add and
// remove transactions and checks every reply against a built-in predictor.
// Depends on sfbt_pkg and the sorted_free_block_table RTL.

module testbench;
  import sfbt_pkg::*;

  localparam int STALL_LIMIT = 20000;  // cycles without any transaction
  localparam int HOLD_CYCLES = 1500;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 600;   // wait after the last expected reply
  localparam int N_PROBES = 20;

  // One expected reply.
  typedef struct {
    logic [COUNT_W-1:0] count;
    status_e            status;
  } table_reply_t;

  // One row of the directed stimulus.
  typedef struct {
    cmd_e               op;
    logic [DISK_W-1:0]  disk;
    logic [BLOCK_W-1:0] block;
    bit                 typed;
    int                 count;
    status_e            status;
  } probe_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  // Predicted table contents, kept in the block's order.
  logic [DISK_W-1:0]  free_disk  [DEPTH];
  logic [BLOCK_W-1:0] free_block [DEPTH];
  int                 free_count;

  table_reply_t expected_replies[$];
  int error_count;
  int replies_seen;
  int adds_sent;
  int removes_sent;
  int ok_seen;
  int miss_seen;
  int full_seen;
  int peak_count;
  bit long_hold_done;

  // Directed rows; typed replies follow from the table contents at a glance.
  probe_row_t probe_rows [N_PROBES] = '{
    '{CMD_REMOVE, 4'd0,  31'd0,          1'b1, 0, STATUS_NOT_FOUND},
    '{CMD_ADD,    4'd0,  31'd0,          1'b1, 1, STATUS_OK},
    '{CMD_ADD,    4'd15, 31'h7FFF_FFFF,  1'b1, 2, STATUS_OK},
    '{CMD_ADD,    4'd15, 31'd0,          1'b1, 3, STATUS_OK},
    '{CMD_ADD,    4'd0,  31'd0,          1'b1, 4, STATUS_OK},
    '{CMD_REMOVE, 4'd15, 31'd0,          1'b1, 3, STATUS_OK},
    '{CMD_REMOVE, 4'd15, 31'd0,          1'b1, 3, STATUS_NOT_FOUND},
    '{CMD_REMOVE, 4'd0,  31'd0,          1'b1, 2, STATUS_OK},
    '{CMD_REMOVE, 4'd0,  31'd0,          1'b1, 1, STATUS_OK},
    '{CMD_REMOVE, 4'd0,  31'd0,          1'b1, 1, STATUS_NOT_FOUND},
    '{CMD_ADD,    4'd7,  31'h5555_5555,  1'b1, 2, STATUS_OK},
    '{CMD_ADD,    4'd8,  31'h2AAA_AAAA,  1'b1, 3, STATUS_OK},
    '{CMD_REMOVE, 4'd7,  31'h2AAA_AAAA,  1'b1, 3, STATUS_NOT_FOUND},
    '{CMD_ADD,    4'd3,  31'd100,        1'b0, 0, STATUS_OK},
    '{CMD_ADD,    4'd3,  31'd100,        1'b0, 0, STATUS_OK},
    '{CMD_ADD,    4'd12, 31'd50,         1'b0, 0, STATUS_OK},
    '{CMD_ADD,    4'd1,  31'h7FFF_FFFF,  1'b0, 0, STATUS_OK},
    '{CMD_REMOVE, 4'd15, 31'h7FFF_FFFF,  1'b1, 6, STATUS_OK},
    '{CMD_REMOVE, 4'd3,  31'd100,        1'b1, 5, STATUS_OK},
    '{CMD_REMOVE, 4'd8,  31'h2AAA_AAAA,  1'b1, 4, STATUS_OK}
  };

  sorted_free_block_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Apply one command to the predicted table and return its status.
  function automatic status_e update_free_table(cmd_e op, logic [DISK_W-1:0] d,
                                                logic [BLOCK_W-1:0] b);
    int pos;
    int hit;
    if (op == CMD_ADD) begin
      if (free_count >= DEPTH) return STATUS_FULL;
      // The pair goes ahead of the first entry with disk >= d and block > b.
      pos = free_count;
      for (int k = 0; k < free_count; k++) begin
        if (pos == free_count && d <= free_disk[k] && b < free_block[k]) pos = k;
      end
      for (int k = free_count; k > pos; k--) begin
        free_disk[k]  = free_disk[k-1];
        free_block[k] = free_block[k-1];
      end
      free_disk[pos]  = d;
      free_block[pos] = b;
      free_count++;
      return STATUS_OK;
    end
    // Removal deletes the first exact match only.
    hit = free_count;
    for (int k = 0; k < free_count; k++) begin
      if (hit == free_count && free_disk[k] == d && free_block[k] == b) hit = k;
    end
    if (hit == free_count) return STATUS_NOT_FOUND;
    for (int k = hit; k + 1 < free_count; k++) begin
      free_disk[k]  = free_disk[k+1];
      free_block[k] = free_block[k+1];
    end
    free_count--;
    return STATUS_OK;
  endfunction

  // Mismatch report: one line each, counted.
  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Random gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(15, 70);
  endfunction

  function automatic logic [DISK_W-1:0] pick_disk();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return DISK_W'($urandom_range(0, 15));
  endfunction

  // Small block numbers make ties and reorders common; the rest span the field.
  function automatic logic [BLOCK_W-1:0] pick_block();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return BLOCK_W'($urandom_range(0, 63));
    if (roll < 45) return '0;
    if (roll < 55) return '1;
    if (roll < 60) return {1'b1, 30'($urandom_range(0, 7))};
    return BLOCK_W'($urandom);
  endfunction

  // Offer one transaction, predict its reply once it is taken, then idle for a random gap that may be empty.
  task automatic send_cmd(cmd_e op, logic [DISK_W-1:0] d, logic [BLOCK_W-1:0] b,
                          bit typed, int want_count, status_e want_status);
    table_reply_t reply;
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(S_TDATA_W - DISK_W - BLOCK_W){1'b0}}, b, d};
    do @(posedge clk_i); while (!s_axis_tready);
    reply.status = update_free_table(op, d, b);
    reply.count  = COUNT_W'(free_count);
    if (typed) begin
      reply.count  = COUNT_W'(want_count);
      reply.status = want_status;
    end
    expected_replies.push_back(reply);
    if (op == CMD_ADD) adds_sent++;
    else removes_sent++;
    if (free_count > peak_count) peak_count = free_count;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // One random command: removes mostly target a pair that is held.
  task automatic send_random(int add_pct);
    int idx;
    if ($urandom_range(0, 99) < add_pct) begin
      send_cmd(CMD_ADD, pick_disk(), pick_block(), 1'b0, 0, STATUS_OK);
    end else if (free_count > 0 && $urandom_range(0, 99) < 75) begin
      idx = $urandom_range(0, free_count - 1);
      send_cmd(CMD_REMOVE, free_disk[idx], free_block[idx], 1'b0, 0, STATUS_OK);
    end else begin
      send_cmd(CMD_REMOVE, pick_disk(), pick_block(), 1'b0, 0, STATUS_OK);
    end
  endtask

  // Reply receiver: random stalls, long ready stretches, one long hold-off.
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!long_hold_done && replies_seen >= 30) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 300)) @(posedge clk_i);
      else repeat ($urandom_range(1, 24)) @(posedge clk_i);
      if (pick_gap() > 0) begin
        m_axis_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
    end
  end

  // Reply checker: each accepted reply against the oldest expectation.
  always @(posedge clk_i) begin
    table_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      replies_seen++;
      case (m_axis_tuser)
        STATUS_OK:        ok_seen++;
        STATUS_NOT_FOUND: miss_seen++;
        STATUS_FULL:      full_seen++;
        default:          ;
      endcase
      if (expected_replies.size() == 0) begin
        $display("[%0t] reply with none expected: count %0d status %0d", $time,
                 m_axis_tdata[COUNT_W-1:0], m_axis_tuser);
        error_count++;
      end else begin
        want = expected_replies.pop_front();
        if (m_axis_tdata[COUNT_W-1:0] !== want.count)
          report_mismatch("entry_count", m_axis_tdata[COUNT_W-1:0], want.count);
        if (m_axis_tuser !== want.status)
          report_mismatch("status", m_axis_tuser, want.status);
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk_i) begin
    int quiet_cycles;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed rows, random phases, drain and verdict.
  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_ADD;
    rst_ni        <= 1'b0;
    free_count     = 0;
    error_count    = 0;
    replies_seen   = 0;
    long_hold_done = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probe_rows[i]) begin
      send_cmd(probe_rows[i].op, probe_rows[i].disk, probe_rows[i].block,
               probe_rows[i].typed, probe_rows[i].count, probe_rows[i].status);
    end

    // Mixed traffic on a small table.
    repeat (80) send_random(60);
    // Fill the table to capacity.
    while (free_count < DEPTH) send_cmd(CMD_ADD, pick_disk(), pick_block(), 1'b0, 0,
                                        STATUS_OK);
    // Refused adds at capacity, mixed with removes that free one slot.
    repeat (24) send_random(70);
    // Removal-heavy traffic on a large table.
    repeat (70) send_random(35);

    s_axis_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d adds and %0d removes; peak table occupancy %0d of %0d.",
             adds_sent, removes_sent, peak_count, DEPTH);
    $display("Replies: %0d ok, %0d not found, %0d refused as full; %0d mismatches.",
             ok_seen, miss_seen, full_seen, error_count);
    if (error_count == 0 && expected_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sfbt_pkg.sv
hw/rtl/sfbt_core.sv
hw/rtl/sorted_free_block_table.sv
tb/sv/testbench.sv
